// ===== src/delta_frame_patch_decoder_core_assert.svh =====
// Assertion macros for the frame patch decoder.
// Included by the top level; needs clock and reset in scope.
`ifndef DELTA_FRAME_PATCH_DECODER_CORE_ASSERT_SVH
`define DELTA_FRAME_PATCH_DECODER_CORE_ASSERT_SVH
// implication checked at every clock edge outside reset
`define DFPD_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dfpd check failed");
// implication checked in the following cycle
`define DFPD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dfpd check failed");
`endif

// ===== src/dfpd_pkg.sv =====
// Package for the frame patch decoder: sizes, codes and the result record.
// No dependencies.
package dfpd_pkg;
   localparam int LIST_BYTES = 1048576;
   localparam int PAGE_BYTES = 4096;
   localparam int LIST_AW    = $clog2(LIST_BYTES);
   localparam int PAGE_AW    = $clog2(PAGE_BYTES);
   localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;
   localparam logic [32:0] MAIN_BOUND  = 33'(16 * 1024 * 1024);
   localparam logic [32:0] AUDIO_BOUND = 33'(2 * 1024 * 1024);
   localparam logic [32:0] ADDR_LIMIT  = 33'(16 * 1024 * 1024);

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_SNAP   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] ST_DECODED   = 2'd0;
   localparam logic [1:0] ST_SKIPPED   = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;
   localparam logic [1:0] ST_OVERSIZE  = 2'd3;

   localparam logic REG_VIDEO = 1'b0;
   localparam logic REG_REGS  = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  region;
      logic [23:0] address;
      logic [31:0] value;
      logic [3:0]  word_index;
      logic [1:0]  status_code;
      logic        checksum_ok;
      logic        video_dirty;
      logic [20:0] list_size;
      logic        out_last;
   } rsp_type;
endpackage

// ===== src/dfpd_stream_if.sv =====
// Valid/ready stream interface carrying one payload of type T.
// Has no dependencies of its own.
interface dfpd_stream_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/dfpd_out_queue.sv =====
// Two-entry result queue between the parser and the rsp channel.
// Depends on dfpd_pkg.
module dfpd_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dfpd_pkg::rsp_type push_data,
   output logic [1:0]       count,
   output logic             out_valid,
   input  logic             out_ready,
   output dfpd_pkg::rsp_type out_data
);
   import dfpd_pkg::*;
   rsp_type    slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_ready && (count_ff != 2'd0);
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ff];
   assign count     = count_ff;

   always_comb begin
      rd_in    = pop ? ~rd_ff : rd_ff;
      wr_in    = push ? ~wr_ff : wr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; count_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end
endmodule

// ===== src/delta_frame_patch_decoder_core.sv =====
// Top level of the frame patch decoder: byte parser, list buffer, sequencer.
// Depends on dfpd_pkg, dfpd_stream_if and dfpd_out_queue.
// The decoder takes one frame byte per transfer and takes no new byte until it is through
// with it: the accepting state, a decode step, any list-buffer pause, then a wait state.
// The wait lasts until a held status is handed over and the two-entry result queue is
// empty again. Pauses come from the list-buffer port: a zero-fill when a delta grows the
// list zeroes one added byte per cycle, and the checksum walk reads four bytes per word
// over the whole words of the stored list length. A status that ends a frame on its last
// checksum byte is held back until the walk has finished.
// There is no clearing pass after reset; a byte of the list never written reads as
// undefined, which only matters for checksums of such frames.
module delta_frame_patch_decoder_core (
   input  logic clock,
   input  logic reset,
   dfpd_stream_if.sink   req,
   dfpd_stream_if.source rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [24:0] csr_data
);
   import dfpd_pkg::*;

   typedef enum logic [4:0] {
      P_FSIZE, P_FNUM, P_SNAP, P_TASIZE, P_DLEN, P_FULL, P_ROFF, P_RLEN, P_RDATA,
      P_DSKIP, P_CSUM, P_NPAGES, P_PREG, P_PIDX, P_PDATA, P_DONE, P_SKIPPED, P_OVERSIZE
   } phase_type;

   typedef enum logic [2:0] {S_IDLE, S_STEP, S_FILL, S_WALK, S_WAIT} seq_type;

   // configuration
   logic [24:0] video_bytes_ff;
   logic [20:0] reg_bytes_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         video_bytes_ff <= 25'd8388608;
         reg_bytes_ff   <= 21'd32768;
      end else if (csr_write) begin
         if (csr_index == REG_VIDEO) video_bytes_ff <= csr_data;
         else reg_bytes_ff <= csr_data[20:0];
      end
   end

   // list memory
   logic [7:0]         mem [LIST_BYTES];
   logic               mem_we;
   logic [LIST_AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]         mem_wdata, mem_rdata_ff;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // parser state
   seq_type     seq_ff, seq_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] shift_ff, shift_in, cnt_ff, cnt_in;
   logic        base_ff, base_in;
   logic [20:0] blen_ff, blen_in, fls_ff, fls_in;
   logic [31:0] drem_ff, drem_in, roff_ff, roff_in;
   logic [15:0] rrem_ff, rrem_in;
   logic [31:0] xacc_ff, xacc_in, pages_ff, pages_in;
   logic [23:0] ptgt_ff, ptgt_in;
   logic [31:0] fnum_ff, fnum_in, tas_ff, tas_in, sent_ff, sent_in;
   logic        vt_ff, vt_in, rapply_ff, rapply_in, ok_ff, ok_in, pok_ff, pok_in;
   logic [7:0]  preg_ff, preg_in;
   logic [21:0] walk_ff, walk_in;   // byte address of the walk, plus one of lag

   logic       push, q_valid;
   logic [1:0] q_count;
   rsp_type    push_data, q_data;

   // secondary result of one step (status after a write, a snapshot or a walk)
   logic    pend_ff, pend_in;
   rsp_type pend_data_ff, pend_data_in;

   logic [31:0] got;
   logic [31:0] acc_shift;
   logic [32:0] off33, bound33;
   logic [3:0]  snap_pos;
   rsp_type     r1, rst;
   logic        r1_v;

   always_comb begin
      seq_in = seq_ff; phase_in = phase_ff; byte_in = byte_ff; last_in = last_ff;
      shift_in = shift_ff; cnt_in = cnt_ff; base_in = base_ff; blen_in = blen_ff;
      fls_in = fls_ff; drem_in = drem_ff; roff_in = roff_ff; rrem_in = rrem_ff;
      xacc_in = xacc_ff; pages_in = pages_ff; ptgt_in = ptgt_ff; fnum_in = fnum_ff;
      tas_in = tas_ff; sent_in = sent_ff; vt_in = vt_ff; rapply_in = rapply_ff;
      ok_in = ok_ff; pok_in = pok_ff; preg_in = preg_ff; walk_in = walk_ff;
      pend_in = pend_ff; pend_data_in = pend_data_ff;
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = byte_ff; mem_raddr = walk_ff[LIST_AW-1:0];
      push = 1'b0; push_data = '0; r1 = '0; r1_v = 1'b0; rst = '0;
      acc_shift = shift_ff | (32'(byte_ff) << {cnt_ff[1:0], 3'b000});
      got = acc_shift; off33 = '0; bound33 = '0; snap_pos = cnt_ff[5:2];
      req.ready = (seq_ff == S_IDLE);

      unique case (seq_ff)
         S_IDLE: begin
            if (req.valid) begin
               byte_in = req.payload.data_byte;
               last_in = req.payload.frame_last;
               seq_in  = S_STEP;
            end
         end
         S_STEP: begin
            // one parse step on byte_ff
            unique case (phase_ff)
               P_FSIZE, P_FNUM, P_TASIZE, P_DLEN, P_CSUM, P_NPAGES, P_PIDX: begin
                  if (phase_ff == P_FNUM) fnum_in = fnum_ff | (32'(byte_ff) << {cnt_ff[1:0], 3'b000});
                  shift_in = acc_shift; cnt_in = cnt_ff + 32'd1;
                  if (cnt_in == 32'd4) begin
                     shift_in = '0; cnt_in = '0;
                     unique case (phase_ff)
                        P_FSIZE: phase_in = P_FNUM;
                        P_FNUM: phase_in = P_SNAP;
                        P_TASIZE: begin tas_in = got; phase_in = P_DLEN; end
                        P_DLEN: begin
                           if (got == tas_ff) begin
                              if (tas_ff > 32'(LIST_BYTES)) phase_in = P_OVERSIZE;
                              else begin
                                 fls_in = tas_ff[20:0]; base_in = 1'b0;
                                 if (tas_ff == 32'd0) begin
                                    blen_in = '0; base_in = 1'b1; phase_in = P_CSUM;
                                 end else begin
                                    drem_in = tas_ff; phase_in = P_FULL;
                                 end
                              end
                           end else if (!base_ff) phase_in = P_SKIPPED;
                           else if (tas_ff > 32'(LIST_BYTES)) phase_in = P_OVERSIZE;
                           else begin
                              fls_in = tas_ff[20:0]; drem_in = got;
                              if (got == 32'd0) phase_in = P_CSUM;
                              else if (got < 32'd4) phase_in = P_DSKIP;
                              else phase_in = P_ROFF;
                              if (32'(blen_ff) < tas_ff) begin
                                 // grow: zero the added bytes first
                                 walk_in = 22'(blen_ff); seq_in = S_FILL;
                              end
                              blen_in = tas_ff[20:0];
                           end
                        end
                        P_CSUM: begin
                           sent_in = got; xacc_in = '0; walk_in = '0;
                           phase_in = P_NPAGES; seq_in = S_WALK;
                        end
                        P_NPAGES: begin
                           pages_in = got; phase_in = (got == 32'd0) ? P_DONE : P_PREG;
                        end
                        default: begin
                           // page index
                           off33 = {got[32-PAGE_AW:0], {PAGE_AW{1'b0}}};
                           unique case (preg_ff)
                              8'd0: bound33 = MAIN_BOUND;
                              8'd1: bound33 = (33'(video_bytes_ff) < ADDR_LIMIT) ?
                                              33'(video_bytes_ff) : ADDR_LIMIT;
                              8'd2: bound33 = AUDIO_BOUND;
                              8'd3: bound33 = 33'(reg_bytes_ff);
                              default: bound33 = '0;
                           endcase
                           pok_in = (got[31:33-PAGE_AW] == '0) && (preg_ff <= 8'd3) &&
                                    (off33 + 33'(PAGE_BYTES) <= bound33);
                           ptgt_in = pok_in ? off33[23:0] : '0;
                           phase_in = P_PDATA;
                        end
                     endcase
                  end
               end
               P_SNAP: begin
                  shift_in = acc_shift;
                  if (cnt_ff[1:0] == 2'd3) begin
                     r1_v = 1'b1; r1.kind = KIND_SNAP; r1.value = acc_shift;
                     r1.word_index = snap_pos; shift_in = '0;
                  end
                  cnt_in = {26'd0, cnt_ff[5:0]} + 32'd1;
                  if (cnt_in == 32'd64) begin cnt_in = '0; phase_in = P_TASIZE; end
               end
               P_FULL: begin
                  mem_we = cnt_ff < 32'(LIST_BYTES);
                  mem_waddr = cnt_ff[LIST_AW-1:0];
                  cnt_in = cnt_ff + 32'd1; drem_in = drem_ff - 32'd1;
                  if (drem_in == 32'd0) begin
                     cnt_in = '0; blen_in = tas_ff[20:0]; base_in = 1'b1; phase_in = P_CSUM;
                  end
               end
               P_ROFF: begin
                  drem_in = drem_ff - 32'd1; shift_in = acc_shift; cnt_in = cnt_ff + 32'd1;
                  if (cnt_in == 32'd4) begin
                     shift_in = '0; cnt_in = '0;
                     if (got == END_MARK) phase_in = (drem_in == 32'd0) ? P_CSUM : P_DSKIP;
                     else begin
                        roff_in = got;
                        if (drem_in < 32'd2) phase_in = (drem_in == 32'd0) ? P_CSUM : P_DSKIP;
                        else phase_in = P_RLEN;
                     end
                  end
               end
               P_RLEN: begin
                  drem_in = drem_ff - 32'd1; shift_in = acc_shift; cnt_in = cnt_ff + 32'd1;
                  if (cnt_in == 32'd2) begin
                     shift_in = '0; cnt_in = '0; rrem_in = got[15:0];
                     rapply_in = (33'(roff_ff) + 33'(got[15:0]) <= 33'(blen_ff)) &&
                                 (32'(got[15:0]) <= drem_in);
                     if (got[15:0] == 16'd0) begin
                        if (drem_in == 32'd0) phase_in = P_CSUM;
                        else if (drem_in < 32'd4) phase_in = P_DSKIP;
                        else phase_in = P_ROFF;
                     end else phase_in = P_RDATA;
                  end
               end
               P_RDATA: begin
                  mem_we = rapply_ff && (roff_ff < 32'(LIST_BYTES));
                  mem_waddr = roff_ff[LIST_AW-1:0];
                  roff_in = roff_ff + 32'd1; rrem_in = rrem_ff - 16'd1;
                  drem_in = drem_ff - 32'd1;
                  if (drem_in == 32'd0) phase_in = P_CSUM;
                  else if (rrem_in == 16'd0) begin
                     if (drem_in < 32'd4) phase_in = P_DSKIP;
                     else phase_in = P_ROFF;
                  end
               end
               P_DSKIP: begin
                  drem_in = drem_ff - 32'd1;
                  if (drem_in == 32'd0) phase_in = P_CSUM;
               end
               P_PREG: begin
                  preg_in = byte_ff; cnt_in = '0; shift_in = '0; phase_in = P_PIDX;
               end
               P_PDATA: begin
                  if (pok_ff) begin
                     r1_v = 1'b1; r1.kind = KIND_WRITE; r1.region = preg_ff[1:0];
                     r1.address = ptgt_ff + cnt_ff[23:0]; r1.value = 32'(byte_ff);
                     if (preg_ff == 8'd1) vt_in = 1'b1;
                  end
                  cnt_in = cnt_ff + 32'd1;
                  if (cnt_in >= 32'(PAGE_BYTES)) begin
                     cnt_in = '0; pages_in = pages_ff - 32'd1;
                     phase_in = (pages_in == 32'd0) ? P_DONE : P_PREG;
                  end
               end
               default: ;
            endcase

            // status result on the last byte of a frame
            rst.kind = KIND_STATUS; rst.value = fnum_in; rst.checksum_ok = ok_in;
            rst.video_dirty = vt_in; rst.out_last = 1'b1;
            priority case (phase_in)
               P_DONE: begin rst.status_code = ST_DECODED; rst.list_size = fls_in; end
               P_SKIPPED: rst.status_code = ST_SKIPPED;
               P_OVERSIZE: rst.status_code = ST_OVERSIZE;
               default: rst.status_code = ST_TRUNCATED;
            endcase
            r1.out_last = !last_ff;
            if (r1_v) begin
               push = 1'b1; push_data = r1;
               if (last_ff) begin pend_in = 1'b1; pend_data_in = rst; end
            end else if (last_ff) begin
               // a status behind the checksum walk waits for its compare
               if (seq_in == S_WALK) begin
                  pend_in = 1'b1; pend_data_in = rst;
               end else begin
                  push = 1'b1; push_data = rst;
               end
            end
            if (last_ff) begin
               phase_in = P_FSIZE; shift_in = '0; cnt_in = '0; fls_in = '0; drem_in = '0;
               roff_in = '0; rrem_in = '0; pages_in = '0; ptgt_in = '0; fnum_in = '0;
               vt_in = 1'b0; tas_in = '0; rapply_in = 1'b0; ok_in = 1'b0; preg_in = '0;
               pok_in = 1'b0;
            end
            if (seq_in == S_STEP) seq_in = S_WAIT;
         end
         S_FILL: begin
            // zero one added byte per cycle
            mem_we = 1'b1; mem_waddr = walk_ff[LIST_AW-1:0]; mem_wdata = 8'd0;
            walk_in = walk_ff + 22'd1;
            if (walk_in == 22'(blen_ff)) seq_in = S_WAIT;
         end
         S_WALK: begin
            // read byte walk_ff; fold byte read last cycle into the accumulator
            if (walk_ff != 22'd0) begin
               shift_in = shift_ff | (32'(mem_rdata_ff) << {walk_ff[1:0] - 2'd1, 3'b000});
               if (walk_ff[1:0] == 2'd0) begin
                  xacc_in = xacc_ff ^ shift_in; shift_in = '0;
               end
            end
            walk_in = walk_ff + 22'd1;
            if ((walk_ff[21:2] == blen_ff[20:2] + 20'd0 && walk_ff[1:0] == 2'd0 &&
                 walk_ff != 22'd0) || (walk_ff == 22'd0 && blen_ff[20:2] == '0)) begin
               shift_in = '0; walk_in = '0;
               // an ended frame takes the compare in its held status
               if (pend_ff) pend_data_in.checksum_ok = (xacc_in == sent_ff);
               else ok_in = (xacc_in == sent_ff);
               seq_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // hand over the pending status, then wait for the queue to drain
            if (pend_ff) begin
               push = 1'b1; push_data = pend_data_ff; pend_in = 1'b0;
            end else if (q_count == 2'd0) seq_in = S_IDLE;
         end
         default: seq_in = S_IDLE;
      endcase
   end

   // sequencer and parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= S_IDLE; phase_ff <= P_FSIZE; shift_ff <= '0; cnt_ff <= '0;
         base_ff <= 1'b0; blen_ff <= '0; fls_ff <= '0; drem_ff <= '0; roff_ff <= '0;
         rrem_ff <= '0; xacc_ff <= '0; pages_ff <= '0; ptgt_ff <= '0; fnum_ff <= '0;
         tas_ff <= '0; sent_ff <= '0; vt_ff <= 1'b0; rapply_ff <= 1'b0; ok_ff <= 1'b0;
         pok_ff <= 1'b0; preg_ff <= '0; walk_ff <= '0; pend_ff <= 1'b0;
         byte_ff <= '0; last_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in; phase_ff <= phase_in; shift_ff <= shift_in; cnt_ff <= cnt_in;
         base_ff <= base_in; blen_ff <= blen_in; fls_ff <= fls_in; drem_ff <= drem_in;
         roff_ff <= roff_in; rrem_ff <= rrem_in; xacc_ff <= xacc_in; pages_ff <= pages_in;
         ptgt_ff <= ptgt_in; fnum_ff <= fnum_in; tas_ff <= tas_in; sent_ff <= sent_in;
         vt_ff <= vt_in; rapply_ff <= rapply_in; ok_ff <= ok_in; pok_ff <= pok_in;
         preg_ff <= preg_in; walk_ff <= walk_in; pend_ff <= pend_in;
         byte_ff <= byte_in; last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
   end

   dfpd_out_queue u_queue (
      .clock, .reset, .push, .push_data, .count(q_count),
      .out_valid(q_valid), .out_ready(rsp.ready), .out_data(q_data)
   );
   assign rsp.valid   = q_valid;
   assign rsp.payload = q_data;

`include "delta_frame_patch_decoder_core_assert.svh"
   // a new byte is only taken with an empty result queue
   `DFPD_ASSERT(a_idle_empty, req.valid && req.ready, q_count == 2'd0)
   // a pending status only sits behind a checksum walk or a wait
   `DFPD_ASSERT(a_pend_wait, pend_ff, (seq_ff == S_WAIT) || (seq_ff == S_WALK))
   // a parse step never overfills the queue
   `DFPD_ASSERT_NEXT(a_step_room, seq_ff == S_STEP, q_count != 2'd3)
endmodule
